// File: design/irac_pkg.sv
package irac_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned CNT_W           = 12;
  localparam int unsigned ADDR_W          = 5;
  localparam int unsigned DATA_W          = 32;

  typedef enum logic [2:0] {
    REG_HDR_MARK   = 3'd0,
    REG_HDR_SPACE  = 3'd1,
    REG_BIT_MARK   = 3'd2,
    REG_ZERO_SPACE = 3'd3,
    REG_ONE_SPACE  = 3'd4,
    REG_FRAME_GAP  = 3'd5,
    REG_IDLE_GAP   = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_HDR1  = 4'd0,
    PH_HSP1  = 4'd1,
    PH_FRM1  = 4'd2,
    PH_STOP1 = 4'd3,
    PH_GAP   = 4'd4,
    PH_HDR2  = 4'd5,
    PH_HSP2  = 4'd6,
    PH_FRM2  = 4'd7,
    PH_STOP2 = 4'd8,
    PH_IDLE  = 4'd9
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] hdr_mark;
    logic [CNT_W-1:0] hdr_space;
    logic [CNT_W-1:0] bit_mark;
    logic [CNT_W-1:0] zero_space;
    logic [CNT_W-1:0] one_space;
    logic [CNT_W-1:0] frame_gap;
    logic [CNT_W-1:0] idle_gap;
  } cfg_t;

  typedef struct packed {
    logic req_type;
    logic heat_mode;
    logic power_on;
  } req_t;

  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_COMMAND = 1'b1;

  localparam logic [CNT_W-1:0] HDR_MARK_RST   = 12'd342;
  localparam logic [CNT_W-1:0] HDR_SPACE_RST  = 12'd148;
  localparam logic [CNT_W-1:0] BIT_MARK_RST   = 12'd28;
  localparam logic [CNT_W-1:0] ZERO_SPACE_RST = 12'd120;
  localparam logic [CNT_W-1:0] ONE_SPACE_RST  = 12'd260;
  localparam logic [CNT_W-1:0] FRAME_GAP_RST  = 12'd2012;
  localparam logic [CNT_W-1:0] IDLE_GAP_RST   = 12'd2250;

  localparam logic [3:0] FRAME1_LAST = 4'd6;
  localparam logic [3:0] FRAME2_LAST = 4'd14;
  localparam logic [3:0] VAR_POS0    = 4'd7;
  localparam logic [3:0] VAR_POS1    = 4'd10;
  localparam logic [3:0] VAR_POS2    = 4'd14;

  // indexed by byte position, wrapped by frame length
  localparam logic [7:0] FIRST_FRAME [16] = '{
    8'h11, 8'hDA, 8'h17, 8'h18, 8'h04, 8'h00, 8'h1E,
    8'h11, 8'hDA, 8'h17, 8'h18, 8'h04, 8'h00, 8'h1E,
    8'h11, 8'hDA
  };

  localparam logic [7:0] SECOND_FRAME [16] = '{
    8'h11, 8'hDA, 8'h17, 8'h18, 8'h00, 8'h73, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h35, 8'h00, 8'h20, 8'h00, 8'h11
  };

  localparam logic [23:0] VAR_RST = {8'h21, 8'h1C, 8'h1F};

  function automatic logic [23:0] decode_cmd(input logic heat, input logic on);
    logic [23:0] b;
    if (!heat) begin
      b = on ? {8'h21, 8'h1C, 8'h1F} : {8'h20, 8'h1C, 8'h1E};
    end else begin
      b = on ? {8'h11, 8'h22, 8'h15} : {8'h10, 8'h22, 8'h14};
    end
    return b;
  endfunction

endpackage

// File: design/irac_if.sv
interface irac_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic heat_mode;
  logic power_on;

  modport source (output valid, output req_type, output heat_mode, output power_on,
                  input ready);
  modport sink   (input valid, input req_type, input heat_mode, input power_on,
                  output ready);
endinterface

interface irac_res_if;
  logic       valid;
  logic       ready;
  logic       ir_level;
  logic       busy_res;
  logic [2:0] queue_count;
  logic       request_dropped;

  modport source (output valid, output ir_level, output busy_res, output queue_count,
                  output request_dropped, input ready);
  modport sink   (input valid, input ir_level, input busy_res, input queue_count,
                  input request_dropped, output ready);
endinterface

// File: design/ir_ac_frame_transmitter.sv
// Channel   | Dir | Payload                                          | Handshake
// in_chan   | in  | req_type, heat_mode, power_on                    | valid/ready
// out_chan  | out | ir_level, busy_res, queue_count, request_dropped | valid/ready
// APB       | in  | 7 x 12-bit timing registers at 4*i               | psel/penable, pready=1
//
// One item per clock sustained while the output is not stalled; each result is registered when its
// item leaves the head of the 2-entry input buffer.
// Result valid is set once an accepted item, stored in the input buffer, fires into the result registers.
// Reset (rst_n low, synchronous) empties the command queue and restores register defaults.
// A stalled output holds its result while the input buffer keeps taking up to two items.
module ir_ac_frame_transmitter #(
  parameter int unsigned QUEUE_DEPTH = irac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  irac_req_if.sink                      in_chan,
  irac_res_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irac_pkg::ADDR_W-1:0]   paddr,
  input  logic [irac_pkg::DATA_W-1:0]   pwdata,
  output logic [irac_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import irac_pkg::*;

  cfg_t cfg;
  logic item_valid;
  req_t item;
  logic item_pop;

  irac_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  irac_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  irac_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_chan   (out_chan)
  );

endmodule

// File: design/irac_cfg.sv
module irac_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irac_pkg::ADDR_W-1:0]   paddr,
  input  logic [irac_pkg::DATA_W-1:0]   pwdata,
  output logic [irac_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output irac_pkg::cfg_t                cfg
);
  import irac_pkg::*;

  cfg_t             cfg_r;
  logic             wr_en;
  logic [2:0]       idx;
  logic [CNT_W-1:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdr_mark   <= HDR_MARK_RST;
      cfg_r.hdr_space  <= HDR_SPACE_RST;
      cfg_r.bit_mark   <= BIT_MARK_RST;
      cfg_r.zero_space <= ZERO_SPACE_RST;
      cfg_r.one_space  <= ONE_SPACE_RST;
      cfg_r.frame_gap  <= FRAME_GAP_RST;
      cfg_r.idle_gap   <= IDLE_GAP_RST;
    end else if (wr_en) begin
      case (idx)
        REG_HDR_MARK:   cfg_r.hdr_mark   <= pwdata[CNT_W-1:0];
        REG_HDR_SPACE:  cfg_r.hdr_space  <= pwdata[CNT_W-1:0];
        REG_BIT_MARK:   cfg_r.bit_mark   <= pwdata[CNT_W-1:0];
        REG_ZERO_SPACE: cfg_r.zero_space <= pwdata[CNT_W-1:0];
        REG_ONE_SPACE:  cfg_r.one_space  <= pwdata[CNT_W-1:0];
        REG_FRAME_GAP:  cfg_r.frame_gap  <= pwdata[CNT_W-1:0];
        REG_IDLE_GAP:   cfg_r.idle_gap   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HDR_MARK:   rd_val = cfg_r.hdr_mark;
      REG_HDR_SPACE:  rd_val = cfg_r.hdr_space;
      REG_BIT_MARK:   rd_val = cfg_r.bit_mark;
      REG_ZERO_SPACE: rd_val = cfg_r.zero_space;
      REG_ONE_SPACE:  rd_val = cfg_r.one_space;
      REG_FRAME_GAP:  rd_val = cfg_r.frame_gap;
      REG_IDLE_GAP:   rd_val = cfg_r.idle_gap;
      default:        rd_val = '0;
    endcase
  end

  assign prdata = DATA_W'(rd_val);

endmodule

// File: design/irac_front.sv
module irac_front (
  input  logic              clk,
  input  logic              rst_n,
  irac_req_if.sink          in_chan,
  output logic              item_valid,
  output irac_pkg::req_t    item,
  input  logic              item_pop
);
  import irac_pkg::*;

  localparam int unsigned SLOTS = 2;

  req_t       slot_r [SLOTS];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_chan.ready = (cnt_r != 2'(SLOTS));
  assign push          = in_chan.valid && in_chan.ready;
  assign item_valid    = (cnt_r != 2'd0);
  assign item          = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = item_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(item_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{req_type:  in_chan.req_type,
                            heat_mode: in_chan.heat_mode,
                            power_on:  in_chan.power_on};
    end
  end

endmodule

// File: design/irac_engine.sv
module irac_engine #(
  parameter int unsigned QUEUE_DEPTH = irac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  irac_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  irac_pkg::req_t    item,
  output logic              item_pop,
  irac_res_if.source        out_chan
);
  import irac_pkg::*;

  localparam int unsigned HEAD_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [1:0]        cmd_mem [QUEUE_DEPTH];
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  tick_r, tick_nxt;
  logic [3:0]        byte_r, byte_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [23:0]       var_r, var_nxt;
  logic              pin_r, pin_nxt;

  logic              out_valid_r;
  logic              res_level_r, res_busy_r, res_dropped_r;
  logic [2:0]        res_count_r;

  logic              fire, is_cmd, full, do_push, dropped, step, pop;
  logic [FILL_W:0]   slot_sum;
  logic [HEAD_W-1:0] slot;
  logic [1:0]        head_cmd;
  logic [CNT_W-1:0]  cnt_wrap, cnt_limit;
  logic              cnt_hit;
  logic [CNT_W:0]    inc1, inc2;
  logic [7:0]        cur_byte, frm2_byte;
  logic              cur_bit;
  logic [CNT_W-1:0]  space_lim;
  logic              in_mark, in_space, bit_done, byte_end, frame_end;

  assign fire     = item_valid && (!out_valid_r || out_chan.ready);
  assign item_pop = fire;
  assign is_cmd   = (item.req_type == REQ_COMMAND);
  assign full     = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign do_push  = fire && is_cmd && !full;
  assign dropped  = is_cmd && full;
  assign step     = fire && !is_cmd && (fill_r != '0);

  assign slot_sum = (FILL_W+1)'(head_r) + (FILL_W+1)'(fill_r);
  assign slot     = (slot_sum >= (FILL_W+1)'(QUEUE_DEPTH))
                    ? HEAD_W'(slot_sum - (FILL_W+1)'(QUEUE_DEPTH)) : HEAD_W'(slot_sum);
  assign head_cmd = cmd_mem[head_r];

  assign cnt_wrap = tick_r + 1'b1;
  always_comb begin
    case (phase_r)
      PH_HDR1, PH_HDR2: cnt_limit = cfg.hdr_mark;
      PH_HSP1, PH_HSP2: cnt_limit = cfg.hdr_space;
      PH_GAP:           cnt_limit = cfg.frame_gap;
      default:          cnt_limit = cfg.idle_gap;
    endcase
  end
  assign cnt_hit = (cnt_wrap == cnt_limit);

  always_comb begin
    case (byte_r)
      VAR_POS0: frm2_byte = var_r[23:16];
      VAR_POS1: frm2_byte = var_r[15:8];
      VAR_POS2: frm2_byte = var_r[7:0];
      default:  frm2_byte = SECOND_FRAME[byte_r];
    endcase
  end

  always_comb begin
    case (phase_r)
      PH_FRM1: cur_byte = FIRST_FRAME[byte_r];
      PH_FRM2: cur_byte = frm2_byte;
      default: cur_byte = 8'h00;
    endcase
  end

  assign cur_bit   = cur_byte[bit_r];
  assign space_lim = cur_bit ? cfg.one_space : cfg.zero_space;
  assign inc1      = {1'b0, tick_r} + 13'd1;
  assign inc2      = {1'b0, tick_r} + 13'd2;
  assign in_mark   = (inc1 < {1'b0, cfg.bit_mark});
  assign in_space  = (inc2 < {1'b0, space_lim});
  assign bit_done  = !in_mark && !in_space;
  assign byte_end  = (bit_r == 3'd7);
  assign frame_end = (phase_r == PH_FRM1) ? (byte_r >= FRAME1_LAST) : (byte_r >= FRAME2_LAST);

  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (phase_r)
        PH_HDR1:  if (cnt_hit) phase_nxt = PH_HSP1;
        PH_HSP1:  if (cnt_hit) phase_nxt = PH_FRM1;
        PH_FRM1:  if (bit_done && byte_end && frame_end) phase_nxt = PH_STOP1;
        PH_STOP1: if (bit_done) phase_nxt = PH_GAP;
        PH_GAP:   if (cnt_hit) phase_nxt = PH_HDR2;
        PH_HDR2:  if (cnt_hit) phase_nxt = PH_HSP2;
        PH_HSP2:  if (cnt_hit) phase_nxt = PH_FRM2;
        PH_FRM2:  if (bit_done && byte_end && frame_end) phase_nxt = PH_STOP2;
        PH_STOP2: if (bit_done) phase_nxt = PH_IDLE;
        PH_IDLE:  if (cnt_hit) phase_nxt = PH_HDR1;
        default:  phase_nxt = PH_HDR1;
      endcase
    end
  end

  always_comb begin
    tick_nxt = tick_r;
    pin_nxt  = pin_r;
    bit_nxt  = bit_r;
    byte_nxt = byte_r;
    var_nxt  = var_r;
    pop      = 1'b0;
    if (step) begin
      case (phase_r)
        PH_HDR1, PH_HDR2, PH_HSP1, PH_HSP2, PH_GAP, PH_IDLE: begin
          tick_nxt = cnt_hit ? '0 : cnt_wrap;
          pin_nxt  = (phase_r == PH_HDR1 || phase_r == PH_HDR2) ? ~pin_r : 1'b0;
          if (phase_r == PH_HDR1 && cnt_hit) var_nxt = decode_cmd(head_cmd[1], head_cmd[0]);
          if (phase_r == PH_IDLE && cnt_hit) pop = 1'b1;
        end
        PH_FRM1, PH_FRM2, PH_STOP1, PH_STOP2: begin
          if (in_mark) begin
            tick_nxt = inc1[CNT_W-1:0];
            pin_nxt  = ~pin_r;
          end else if (in_space) begin
            tick_nxt = inc2[CNT_W-1:0];
            pin_nxt  = 1'b0;
          end else begin
            tick_nxt = '0;
            if (phase_r == PH_FRM1 || phase_r == PH_FRM2) begin
              bit_nxt = bit_r + 3'd1;
              if (byte_end) byte_nxt = frame_end ? 4'd0 : byte_r + 4'd1;
            end
          end
        end
        default: tick_nxt = '0;
      endcase
    end
  end

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (do_push) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop) begin
      fill_nxt = fill_r - 1'b1;
      head_nxt = (head_r == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) cmd_mem[slot] <= {item.heat_mode, item.power_on};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      phase_r     <= PH_HDR1;
      tick_r      <= '0;
      byte_r      <= '0;
      bit_r       <= '0;
      var_r       <= VAR_RST;
      pin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      byte_r  <= byte_nxt;
      bit_r   <= bit_nxt;
      var_r   <= var_nxt;
      pin_r   <= pin_nxt;
      if (fire) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_level_r   <= pin_nxt;
      res_busy_r    <= (fill_nxt != '0);
      res_count_r   <= 3'(fill_nxt);
      res_dropped_r <= dropped;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.ir_level        = res_level_r;
  assign out_chan.busy_res        = res_busy_r;
  assign out_chan.queue_count     = res_count_r;
  assign out_chan.request_dropped = res_dropped_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_cmd && full |=> res_dropped_r && out_valid_r)
    else $error("full-queue command not flagged");

  a_send_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_HDR1 |-> fill_r != '0)
    else $error("sender active with empty queue");

  a_pop_only_step: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < $past(fill_r) |-> $past(step) && $past(phase_r) == PH_IDLE)
    else $error("queue popped outside idle gap");

endmodule
